@@ src/plm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

	// Field and state widths.
	localparam int unsigned TIME_W  = 63;
	localparam int unsigned SUM_W   = 64;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned RATE_W  = 38;
	localparam int unsigned MS_W    = 20;
	localparam int unsigned LIMIT_W = 40;
	localparam int unsigned ITER_W  = 7;

	// Opcodes of an input word and kinds of a result word.
	localparam logic OP_SOURCE     = 1'b0;
	localparam logic OP_SINK       = 1'b1;
	localparam logic KIND_FRAME    = 1'b0;
	localparam logic KIND_INTERVAL = 1'b1;

	// Arithmetic constants.
	localparam logic [MS_W-1:0]    NS_PER_MS         = 20'd1000000;
	localparam logic [MS_W-1:0]    INTERVAL_MS_RESET = 20'd1000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET       = 40'd1000000000;
	localparam logic [RATE_W-1:0]  RATE_NUM          = 38'd256000000000;
	localparam logic [CNT_W-1:0]   CNT_MAX           = '1;

	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [RATE_W-1:0]  rate_t;
	typedef logic [ITER_W-1:0]  iter_t;

	// Request to the shared divider: dividend / divisor, one quotient bit per
	// cycle for iters quotient bits, taking dividend bits from the top down.
	typedef struct packed {
		logic  start;
		sum_t  dividend;
		time_t divisor;
		iter_t iters;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		sum_t quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ src/plm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  plm_pkg::div_req_t req,
	output plm_pkg::div_rsp_t rsp
);
	import plm_pkg::*;

	logic  busy_q;
	logic  done_q;
	iter_t cnt_q;
	sum_t  rem_q;
	sum_t  dvd_q;
	sum_t  quo_q;
	time_t dvs_q;

	sum_t shifted;
	sum_t dvs_ext;
	logic ge;

	// The remainder always stays below the divisor, so its top bit is zero and
	// the shifted partial remainder still fits in the word.
	assign shifted = {rem_q[SUM_W-2:0], dvd_q[SUM_W-1]};
	assign dvs_ext = {1'b0, dvs_q};
	assign ge      = (shifted >= dvs_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == iter_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - dvs_ext) : shifted;
			quo_q <= {quo_q[SUM_W-2:0], ge};
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

@@ src/pipeline_latency_monitor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame latency monitor.
// Input channel (in_valid/in_ready) carries one event word: opcode 0 marks a
// frame stamped at the source, opcode 1 a frame that reached the sink, with
// the current time and the frame's source stamp in nanoseconds.
// Output channel (out_valid/out_ready) carries result words: every sink word
// gives a per-frame word, and when the statistics interval has run its full
// length a second, interval word follows. The last flag marks the final word.
// A source word is absorbed in the idle state and in_ready stays high. A sink
// word passes update, check, the divisions and emit to give the per-frame word,
// and the divisions and emit once more when it closes the interval; in_ready
// returns with the final word. One shared radix-2 divider yields one quotient
// bit per cycle: 64 bits for the average, 64 for the period and 38 for the
// rate. A zero period skips the rate division and gives a zero rate.
// The result sits in an output register, so a stalled receiver only holds the
// sequencer at the point where the next word must be loaded.
// The interval length (milliseconds) is written on cfg_wr_en/cfg_wr_data.
// Reset clears all statistics and sets the interval to one second.
module pipeline_latency_monitor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [plm_pkg::MS_W-1:0]   cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic [plm_pkg::TIME_W-1:0] now_time,
	input  logic [plm_pkg::TIME_W-1:0] frame_start_time,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [plm_pkg::TIME_W-1:0] latency_or_span,
	output logic [plm_pkg::TIME_W-1:0] average,
	output logic [plm_pkg::TIME_W-1:0] minimum,
	output logic [plm_pkg::TIME_W-1:0] maximum,
	output logic [plm_pkg::TIME_W-1:0] period,
	output logic [plm_pkg::RATE_W-1:0] rate_x256,
	output logic [plm_pkg::CNT_W-1:0]  frame_total,
	output logic                   last
);
	import plm_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_UPDATE    = 3'd1;
	localparam logic [2:0] ST_CHECK     = 3'd2;
	localparam logic [2:0] ST_DIV_START = 3'd3;
	localparam logic [2:0] ST_DIV_WAIT  = 3'd4;
	localparam logic [2:0] ST_EMIT      = 3'd5;

	// Which quotient the divider is producing for the current result word.
	localparam logic [1:0] PH_AVG  = 2'd0;
	localparam logic [1:0] PH_PER  = 2'd1;
	localparam logic [1:0] PH_RATE = 2'd2;

	localparam int unsigned RATE_SHIFT = SUM_W - RATE_W;

	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic       kind_q;
	logic       closes_q;

	logic [LIMIT_W-1:0] limit_q;

	time_t first_time_q;
	cnt_t  count_all_q;
	sum_t  sum_all_q;
	time_t min_all_q;
	time_t max_all_q;
	time_t window_start_q;
	cnt_t  window_count_q;
	sum_t  window_sum_q;
	time_t window_min_q;
	time_t window_max_q;

	time_t now_q;
	time_t lat_q;
	time_t span_q;
	time_t perdiff_q;
	time_t avg_q;
	time_t per_q;
	rate_t rate_q;

	logic  out_valid_q;
	logic  kind_out_q;
	time_t lat_out_q;
	time_t avg_out_q;
	time_t min_out_q;
	time_t max_out_q;
	time_t per_out_q;
	rate_t rate_out_q;
	cnt_t  total_out_q;
	logic  last_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_acc;
	logic out_free;
	logic rate_skip;
	logic [SUM_W:0] sum_all_add;
	logic [SUM_W:0] window_sum_add;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign rate_skip = (phase_q == PH_RATE) && (per_q == '0);

	assign sum_all_add    = {1'b0, sum_all_q} + {2'b0, lat_q};
	assign window_sum_add = {1'b0, window_sum_q} + {2'b0, lat_q};

	// Divider operands, chosen by the phase and the kind of result word.
	always_comb begin
		div_req.start    = (state_q == ST_DIV_START) && !rate_skip;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		div_req.iters    = iter_t'(SUM_W);
		unique case (phase_q)
			PH_AVG: begin
				div_req.dividend = (kind_q == KIND_FRAME) ? sum_all_q : window_sum_q;
				div_req.divisor  = time_t'((kind_q == KIND_FRAME) ? count_all_q
				                                                  : window_count_q);
			end
			PH_PER: begin
				div_req.dividend = {1'b0, (kind_q == KIND_FRAME) ? perdiff_q : span_q};
				div_req.divisor  = time_t'((kind_q == KIND_FRAME) ? count_all_q
				                                                  : window_count_q);
			end
			PH_RATE: begin
				// The numerator sits at the top so that only its own bits are walked.
				div_req.dividend = {RATE_NUM, {RATE_SHIFT{1'b0}}};
				div_req.divisor  = per_q;
				div_req.iters    = iter_t'(RATE_W);
			end
			default: begin
				div_req.dividend = '0;
			end
		endcase
	end

	plm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control state and the running statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_AVG;
			kind_q         <= KIND_FRAME;
			closes_q       <= 1'b0;
			limit_q        <= LIMIT_RESET;
			first_time_q   <= '0;
			count_all_q    <= '0;
			sum_all_q      <= '0;
			min_all_q      <= '1;
			max_all_q      <= '0;
			window_start_q <= '0;
			window_count_q <= '0;
			window_sum_q   <= '0;
			window_min_q   <= '1;
			window_max_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// The interval limit is kept in nanoseconds, so the product is
			// formed once per write rather than on every sink word.
			if (cfg_wr_en) begin
				limit_q <= LIMIT_W'(cfg_wr_data) * LIMIT_W'(NS_PER_MS);
			end
			// In the emit state a new word is loaded whenever the output register is
			// free or is being emptied in the same cycle.
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (opcode == OP_SINK) begin
							state_q <= ST_UPDATE;
						end else if (first_time_q == '0) begin
							// A source stamp at time zero leaves the first time unset.
							first_time_q   <= now_time;
							window_start_q <= now_time;
							window_count_q <= '0;
							window_sum_q   <= '0;
							window_min_q   <= '1;
							window_max_q   <= '0;
						end
					end
				end
				ST_UPDATE: begin
					if (count_all_q != CNT_MAX) begin
						count_all_q <= count_all_q + 1'b1;
					end
					if (window_count_q != CNT_MAX) begin
						window_count_q <= window_count_q + 1'b1;
					end
					sum_all_q    <= sum_all_add[SUM_W] ? '1 : sum_all_add[SUM_W-1:0];
					window_sum_q <= window_sum_add[SUM_W] ? '1 : window_sum_add[SUM_W-1:0];
					if (lat_q < min_all_q) begin
						min_all_q <= lat_q;
					end
					if (lat_q > max_all_q) begin
						max_all_q <= lat_q;
					end
					if (lat_q < window_min_q) begin
						window_min_q <= lat_q;
					end
					if (lat_q > window_max_q) begin
						window_max_q <= lat_q;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					closes_q <= ({1'b0, span_q} >= (TIME_W + 1)'(limit_q));
					kind_q   <= KIND_FRAME;
					phase_q  <= PH_AVG;
					state_q  <= ST_DIV_START;
				end
				ST_DIV_START: begin
					// A zero period gives a zero rate without a division.
					state_q <= rate_skip ? ST_EMIT : ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						unique case (phase_q)
							PH_AVG: begin
								phase_q <= PH_PER;
								state_q <= ST_DIV_START;
							end
							PH_PER: begin
								phase_q <= PH_RATE;
								state_q <= ST_DIV_START;
							end
							PH_RATE: begin
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (kind_q == KIND_FRAME && closes_q) begin
							kind_q  <= KIND_INTERVAL;
							phase_q <= PH_AVG;
							state_q <= ST_DIV_START;
						end else begin
							if (kind_q == KIND_INTERVAL) begin
								window_start_q <= now_q;
								window_count_q <= '0;
								window_sum_q   <= '0;
								window_min_q   <= '1;
								window_max_q   <= '0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working values and the output word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q <= now_time;
			lat_q <= (now_time >= frame_start_time) ? (now_time - frame_start_time) : '0;
		end
		if (state_q == ST_UPDATE) begin
			// With no first time yet the period runs from time zero.
			span_q    <= (now_q >= window_start_q) ? (now_q - window_start_q) : '0;
			perdiff_q <= (now_q >= first_time_q) ? (now_q - first_time_q) : '0;
		end
		if (state_q == ST_DIV_START && rate_skip) begin
			rate_q <= '0;
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			unique case (phase_q)
				PH_AVG:  avg_q  <= div_rsp.quotient[TIME_W-1:0];
				PH_PER:  per_q  <= div_rsp.quotient[TIME_W-1:0];
				PH_RATE: rate_q <= div_rsp.quotient[RATE_W-1:0];
				default: avg_q  <= avg_q;
			endcase
		end
		if (state_q == ST_EMIT && out_free) begin
			kind_out_q <= kind_q;
			avg_out_q  <= avg_q;
			per_out_q  <= per_q;
			rate_out_q <= rate_q;
			if (kind_q == KIND_FRAME) begin
				lat_out_q   <= lat_q;
				min_out_q   <= min_all_q;
				max_out_q   <= max_all_q;
				total_out_q <= count_all_q;
				last_out_q  <= !closes_q;
			end else begin
				lat_out_q   <= span_q;
				min_out_q   <= window_min_q;
				max_out_q   <= window_max_q;
				total_out_q <= '0;
				last_out_q  <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_out_q;
	assign latency_or_span = lat_out_q;
	assign average         = avg_out_q;
	assign minimum         = min_out_q;
	assign maximum         = max_out_q;
	assign period          = per_out_q;
	assign rate_x256       = rate_out_q;
	assign frame_total     = total_out_q;
	assign last            = last_out_q;

	// The divider only reports a finished quotient while the sequencer waits.
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside the wait state");

	// An interval word always ends the words of its event.
	a_interval_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_INTERVAL) |-> last)
		else $error("interval word not marked last");

	// The interval never counts more frames than the lifetime count.
	a_window_count: assert property (@(posedge clk) disable iff (!arst_n)
		window_count_q <= count_all_q)
		else $error("interval count above lifetime count");

	// Once any frame has been seen, the lifetime minimum cannot exceed the maximum.
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_all_q != '0) |-> (min_all_q <= max_all_q))
		else $error("lifetime minimum above maximum");

endmodule

`default_nettype wire

@@ test/pipeline_latency_monitor_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the frame latency monitor.
// Event words go in on the input channel. A behavioural model inside the bench
// follows every accepted word and queues the result words that it should cause.
// Each result word that the block hands over is compared, field by field, with
// the oldest queued word. The run starts with a short walk through a table of
// hand-picked words. After that come random phases, each setting an interval
// length. Both channels idle at random, and one phase in four runs without gaps.
module pipeline_latency_monitor_tb;
	import plm_pkg::*;

	localparam int unsigned HALF_PERIOD     = 6;
	localparam int unsigned RESET_CYCLES    = 5;
	localparam int unsigned DRAIN_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT  = 5000;
	localparam int unsigned PHASES          = 9;
	localparam int unsigned SINKS_PER_PHASE = 138;
	localparam int unsigned MAX_REPORTS     = 40;
	localparam time_t       TIME_MAX        = '1;

	// One result word, laid out as the output ports.
	typedef struct packed {
		logic  kind;
		time_t latency_or_span;
		time_t average;
		time_t minimum;
		time_t maximum;
		time_t period;
		rate_t rate_x256;
		cnt_t  frame_total;
		logic  last;
	} stats_word_t;

	// One row of the directed table. A row is either an interval write or an
	// event word. An event word may carry a hand-written first result.
	typedef struct packed {
		logic            is_cfg;
		logic [MS_W-1:0] cfg_val;
		logic            op;
		time_t           now_v;
		time_t           fst_v;
		logic            typed;
		stats_word_t     want;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [MS_W-1:0] cfg_wr_data;
	logic            in_valid;
	logic            in_ready;
	logic            opcode;
	time_t           now_time;
	time_t           frame_start_time;
	logic            out_valid;
	logic            out_ready;
	logic            kind;
	time_t           latency_or_span;
	time_t           average;
	time_t           minimum;
	time_t           maximum;
	time_t           period;
	rate_t           rate_x256;
	cnt_t            frame_total;
	logic            last;

	pipeline_latency_monitor dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.now_time         (now_time),
		.frame_start_time (frame_start_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.latency_or_span  (latency_or_span),
		.average          (average),
		.minimum          (minimum),
		.maximum          (maximum),
		.period           (period),
		.rate_x256        (rate_x256),
		.frame_total      (frame_total),
		.last             (last)
	);

	// Model state. It mirrors the block's statistics registers and is set to
	// the reset values at time zero.
	logic [MS_W-1:0] interval_len_ms;
	time_t           first_stamp;
	cnt_t            frames_all;
	sum_t            lat_sum_all;
	time_t           lat_min_all;
	time_t           lat_max_all;
	time_t           win_start;
	cnt_t            win_frames;
	sum_t            win_sum;
	time_t           win_min;
	time_t           win_max;

	stats_word_t     pending_stats[$];
	stim_row_t       directed_rows[$];
	int unsigned     mismatches = 0;
	int unsigned     idle_cycles;
	// When set, neither side idles, so that the block also sees back-to-back
	// traffic.
	logic            calm;

	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Most gaps are short, a few are long.
	function automatic int idle_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic time_t rand_time();
		return time_t'({$urandom, $urandom});
	endfunction

	// A time difference that would be negative is taken as zero.
	function automatic time_t elapsed(time_t later, time_t earlier);
		return (later >= earlier) ? later - earlier : '0;
	endfunction

	function automatic sum_t add_sat(sum_t acc, time_t lat);
		logic [SUM_W:0] wide;
		wide = {1'b0, acc} + {2'b00, lat};
		return wide[SUM_W] ? '1 : wide[SUM_W-1:0];
	endfunction

	function automatic cnt_t inc_sat(cnt_t c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic rate_t frame_rate(time_t per);
		if (per == '0)
			return '0;
		return rate_t'(sum_t'(RATE_NUM) / sum_t'(per));
	endfunction

	task automatic restart_window(input time_t at);
		win_start  = at;
		win_frames = '0;
		win_sum    = '0;
		win_min    = TIME_MAX;
		win_max    = '0;
	endtask

	// Follows one accepted event word and gives the result words that it causes.
	task automatic predict_word(input logic op, input time_t now_v, input time_t fst_v,
			output int n, output stats_word_t frame_word, output stats_word_t win_word);
		time_t lat;
		time_t per;
		time_t span;
		logic  closes;
		n          = 0;
		frame_word = '0;
		win_word   = '0;
		if (op == OP_SOURCE) begin
			// A source word has an effect only while the first stamp is still zero.
			if (first_stamp == '0) begin
				restart_window(now_v);
				first_stamp = now_v;
			end
		end else begin
			lat         = elapsed(now_v, fst_v);
			frames_all  = inc_sat(frames_all);
			lat_sum_all = add_sat(lat_sum_all, lat);
			if (lat < lat_min_all)
				lat_min_all = lat;
			if (lat > lat_max_all)
				lat_max_all = lat;
			// Before any source word, first_stamp is zero and the period is
			// taken from the sink time itself.
			per = elapsed(now_v, first_stamp) / time_t'(frames_all);

			win_frames = inc_sat(win_frames);
			win_sum    = add_sat(win_sum, lat);
			if (lat < win_min)
				win_min = lat;
			if (lat > win_max)
				win_max = lat;
			span   = elapsed(now_v, win_start);
			closes = sum_t'(span) >= sum_t'(interval_len_ms) * sum_t'(NS_PER_MS);

			frame_word.kind            = KIND_FRAME;
			frame_word.latency_or_span = lat;
			frame_word.average         = time_t'(lat_sum_all / sum_t'(frames_all));
			frame_word.minimum         = lat_min_all;
			frame_word.maximum         = lat_max_all;
			frame_word.period          = per;
			frame_word.rate_x256       = frame_rate(per);
			frame_word.frame_total     = frames_all;
			frame_word.last            = !closes;
			n = 1;
			if (closes) begin
				win_word.kind            = KIND_INTERVAL;
				win_word.latency_or_span = span;
				win_word.average         = time_t'(win_sum / sum_t'(win_frames));
				win_word.minimum         = win_min;
				win_word.maximum         = win_max;
				win_word.period          = span / time_t'(win_frames);
				win_word.rate_x256       = frame_rate(win_word.period);
				win_word.frame_total     = '0;
				win_word.last            = 1'b1;
				restart_window(now_v);
				n = 2;
			end
		end
	endtask

	task automatic add_word(input logic op, input time_t now_v, input time_t fst_v);
		stim_row_t r;
		r       = '0;
		r.op    = op;
		r.now_v = now_v;
		r.fst_v = fst_v;
		directed_rows.push_back(r);
	endtask

	task automatic add_checked(input time_t now_v, input time_t fst_v, input stats_word_t want);
		stim_row_t r;
		r       = '0;
		r.op    = OP_SINK;
		r.now_v = now_v;
		r.fst_v = fst_v;
		r.typed = 1'b1;
		r.want  = want;
		directed_rows.push_back(r);
	endtask

	task automatic add_cfg(input logic [MS_W-1:0] len_ms);
		stim_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_val = len_ms;
		directed_rows.push_back(r);
	endtask

	// Presents one event word after a random gap and waits until it is taken.
	// With no gap, valid simply stays high and the payload moves on.
	task automatic send_word(input logic op, input time_t now_v, input time_t fst_v,
			input logic typed, input stats_word_t want);
		int          gap;
		int          n;
		stats_word_t frame_word;
		stats_word_t win_word;
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid         <= 1'b1;
		opcode           <= op;
		now_time         <= now_v;
		frame_start_time <= fst_v;
		do @(posedge clk); while (!in_ready);
		predict_word(op, now_v, fst_v, n, frame_word, win_word);
		if (n > 0)
			pending_stats.push_back(typed ? want : frame_word);
		if (n > 1)
			pending_stats.push_back(win_word);
	endtask

	// The interval is only rewritten while the block is idle. A source word
	// causes no result, so a further pause covers one that may still be in
	// flight.
	task automatic write_interval(input logic [MS_W-1:0] len_ms);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len_ms;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		interval_len_ms = len_ms;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// The receiver stalls at random. Each change of out_ready falls on its own
	// falling edge.
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = idle_gap();
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// Result words are taken at the rising edge and matched in order.
	always @(posedge clk) begin
		stats_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result word with none expected, kind %0d span %0d",
						$time, kind, latency_or_span);
			end else begin
				want = pending_stats.pop_front();
				check_field("kind", want.kind, kind);
				check_field("latency_or_span", want.latency_or_span, latency_or_span);
				check_field("average", want.average, average);
				check_field("minimum", want.minimum, minimum);
				check_field("maximum", want.maximum, maximum);
				check_field("period", want.period, period);
				check_field("rate_x256", want.rate_x256, rate_x256);
				check_field("frame_total", want.frame_total, frame_total);
				check_field("last", want.last, last);
			end
		end
	end

	// The watchdog ends a run that has stopped moving on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("pipeline_latency_monitor_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t       row;
		int unsigned     phase;
		int unsigned     sinks;
		int unsigned     pick;
		time_t           clock_ns;
		time_t           now_v;
		time_t           fst_v;
		time_t           lat_v;
		sum_t            len_ns;
		sum_t            step_cap;
		sum_t            step;
		logic [MS_W-1:0] len_ms;

		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		in_valid         = 1'b0;
		opcode           = OP_SOURCE;
		now_time         = '0;
		frame_start_time = '0;
		calm             = 1'b0;

		interval_len_ms = INTERVAL_MS_RESET;
		first_stamp     = '0;
		frames_all      = '0;
		lat_sum_all     = '0;
		lat_min_all     = TIME_MAX;
		lat_max_all     = '0;
		restart_window('0);

		// Straight after reset a sink word at time zero gives zeros all round,
		// and a rate of zero because the period is zero.
		add_checked('0, '0, stats_word_t'({KIND_FRAME, 63'd0, 63'd0, 63'd0, 63'd0,
			63'd0, 38'd0, 32'd1, 1'b1}));
		// A frame stamped after the current time has its latency floored at zero.
		add_checked('0, TIME_MAX, stats_word_t'({KIND_FRAME, 63'd0, 63'd0, 63'd0,
			63'd0, 63'd0, 38'd0, 32'd2, 1'b1}));
		// The largest latency closes the interval. Repeated, it drives the sum
		// into saturation.
		add_word(OP_SINK, TIME_MAX, '0);
		add_word(OP_SINK, TIME_MAX, '0);
		add_word(OP_SINK, TIME_MAX, '0);
		// A source word at time zero leaves the first-frame time unset.
		add_word(OP_SOURCE, '0, TIME_MAX);
		add_word(OP_SINK, 63'd7, 63'd3);
		add_word(OP_SOURCE, 63'd1000, '0);
		// Once the first-frame time is set, further source words are ignored.
		add_word(OP_SOURCE, 63'd5000, 63'd77);
		// The current time lies before the first-frame time here.
		add_word(OP_SINK, 63'd500, 63'd100);
		// With a zero interval, every sink word also closes the interval.
		add_cfg('0);
		add_word(OP_SINK, 63'd2000, 63'd1500);
		// One millisecond: one nanosecond short of the boundary, then exactly on it.
		add_cfg(20'd1);
		add_word(OP_SINK, 63'd1001999, 63'd2000);
		add_word(OP_SINK, 63'd1002000, 63'd1001000);
		add_cfg(20'd1000000);
		add_word(OP_SINK, TIME_MAX, TIME_MAX - 63'd1);
		// The interval now starts at the top of the range, so the span is floored.
		add_word(OP_SINK, 63'd3000, '0);
		add_cfg('0);
		add_word(OP_SINK, 63'd4000, 63'd4000);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg)
				write_interval(row.cfg_val);
			else
				send_word(row.op, row.now_v, row.fst_v, row.typed, row.want);
		end

		// Random phases. Each phase first aligns the interval to its own time
		// line. For this, one sink word goes in under a zero interval. Then the
		// phase length is written. Time steps scale with the interval, so that
		// intervals close every few frames. The last words of a phase use times
		// anywhere in the range.
		clock_ns = time_t'(64'd1 << 20);
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: len_ms = '0;
				1: len_ms = 20'd1;
				2: len_ms = 20'd1000000;
				3: len_ms = 20'd2;
				4: len_ms = MS_W'($urandom_range(3, 40));
				5: len_ms = INTERVAL_MS_RESET;
				6: len_ms = 20'd5;
				7: len_ms = MS_W'($urandom_range(0, 1000000));
				default: len_ms = 20'd1;
			endcase
			calm = (phase % 4 == 3);
			write_interval('0);
			send_word(OP_SINK, clock_ns, clock_ns, 1'b0, '0);
			write_interval(len_ms);
			len_ns   = sum_t'(len_ms) * sum_t'(NS_PER_MS);
			step_cap = len_ns / 3 + 1000;
			sinks    = 0;
			while (sinks < SINKS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// A stray source word, ignored once the first frame is known.
					now_v = ($urandom_range(0, 1) != 0) ? clock_ns : rand_time();
					send_word(OP_SOURCE, now_v, rand_time(), 1'b0, '0);
				end else begin
					if (pick < 12)
						step = len_ns;
					else
						step = sum_t'({$urandom, $urandom}) % (step_cap + 1);
					clock_ns = clock_ns + time_t'(step);
					now_v = (sinks + 4 >= SINKS_PER_PHASE) ? rand_time() : clock_ns;
					pick = $urandom_range(0, 99);
					if (pick < 75) begin
						lat_v = time_t'($urandom_range(0, 1 << 20));
						fst_v = (lat_v <= now_v) ? now_v - lat_v : '0;
					end else if (pick < 85) begin
						fst_v = now_v + time_t'($urandom_range(1, 5000));
					end else if (pick < 95) begin
						fst_v = rand_time();
					end else begin
						fst_v = now_v;
					end
					send_word(OP_SINK, now_v, fst_v, 1'b0, '0);
					sinks++;
				end
			end
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("pipeline_latency_monitor_tb passed");
		else
			$display("pipeline_latency_monitor_tb failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/plm_pkg.sv
src/plm_div.sv
src/pipeline_latency_monitor.sv
test/pipeline_latency_monitor_tb.sv
